// ===== hdl/fpd_pkg.sv =====
package fpd_pkg;

   localparam int COEF_WORDS  = 26;
   localparam int COEF_AW     = 5;
   localparam int WEIGHT_BASE = 14;
   localparam int RULE_COUNT  = 12;
   localparam logic signed [31:0] Q_ONE   = 32'sd65536;
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   localparam logic [1:0] REG_ERROR_GAIN  = 2'd0;
   localparam logic [1:0] REG_CHANGE_GAIN = 2'd1;
   localparam logic [1:0] REG_OUTPUT_GAIN = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh7FFFFFFF) return SAT_MAX;
      if (v < -66'sh80000000) return SAT_MIN;
      return v[31:0];
   endfunction

   // error set slot in the table, order NB, NS, PB, PS
   function automatic logic [1:0] err_slot(input logic [1:0] k);
      case (k)
         2'd0: return 2'd0;
         2'd1: return 2'd1;
         2'd2: return 2'd3;
         default: return 2'd2;
      endcase
   endfunction

endpackage

// ===== hdl/fuzzy_pd_controller.sv =====
// A load beat is written in the cycle it is taken, one load per cycle while idle
// with no result waiting. A sample beat runs through the shared 64-step restoring
// divider (one quotient bit per cycle) for both gains, seven memberships and the
// average; the average division is skipped when the rule strengths sum to zero.
// One beat at a time; the next sample is taken the cycle after its result is accepted.
// Reset (synchronous): gains to 1.0, previous error to 0, and a clearing pass over
// all 32 words of the coefficient RAM, during which req_tready is low.
module fuzzy_pd_controller
   import fpd_pkg::*;
#(
   parameter int COEF_DEPTH = 2 ** COEF_AW
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[0], measured[32:1], reference[64:33], coef_index[69:65],
   // coef_value[101:70], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // drive[31:0]
   output logic [31:0]  rsp_tdata,
   // zero_weight
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int AW = $clog2(COEF_DEPTH);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ERR, S_X1, S_X2, S_MRD, S_MWAIT, S_MDIST, S_MDIV,
      S_MFIN, S_RULE_RD, S_RULE_WAIT, S_RULE_S, S_RULE_NUM, S_RULE_ACC,
      S_AVG, S_AVGDIV, S_OUTMUL, S_OUT
   } state_type;

   state_type state_ff;
   logic [30:0] egain_ff, cgain_ff;
   logic signed [31:0] ogain_ff;
   logic signed [31:0] prev_ff, e_ff, de_ff, x1_ff, x2_ff;
   logic signed [31:0] me_ff [4];
   logic signed [31:0] mc_ff [3];
   logic [AW-1:0] clr_ff;
   logic [2:0] mk_ff;
   logic [3:0] rk_ff;
   logic signed [31:0] centre_ff, s_ff, w_ff;
   logic signed [40:0] den_ff, num_ff;
   logic signed [31:0] out_ff;
   logic zw_ff, ovalid_ff;

   // shared divider: q = sat((n<<16)/d), trunc toward zero
   logic [63:0] dv_rem_ff, dv_num_ff;
   logic [63:0] dv_den_ff;
   logic [63:0] dv_q_ff;
   logic [6:0]  dv_cnt_ff;
   logic        dv_neg_ff, dv_zero_ff, dv_npos_ff, dv_nzero_ff;
   logic               dv_go;
   logic signed [31:0] dv_n;
   logic signed [32:0] dv_d;

   // RAM
   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0]   ram_wd, ram_rd;

   logic op;
   logic signed [31:0] measured, reference, coef_value;
   logic [4:0] coef_index;
   assign op         = req_tdata[0];
   assign measured   = req_tdata[32:1];
   assign reference  = req_tdata[64:33];
   assign coef_index = req_tdata[69:65];
   assign coef_value = req_tdata[101:70];

   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = zw_ff;

   logic acc;
   assign acc = req_tvalid && req_tready;

   always_comb begin
      ram_we = 1'b0;
      ram_wa = clr_ff;
      ram_wd = '0;
      if (state_ff == S_CLEAR) ram_we = 1'b1;
      else if (acc && op == OP_LOAD && coef_index < 5'(COEF_WORDS)) begin
         ram_we = 1'b1;
         ram_wa = AW'(coef_index);
         ram_wd = coef_value;
      end
   end

   always_comb begin
      ram_ra = '0;
      if (state_ff == S_MRD) ram_ra = AW'({mk_ff < 3'd4 ? {2'd0, err_slot(mk_ff[1:0])}
                                           : {1'b0, mk_ff}, 1'b0});
      else if (state_ff == S_MWAIT) ram_ra = AW'({mk_ff < 3'd4 ?
                                           {2'd0, err_slot(mk_ff[1:0])} : {1'b0, mk_ff}, 1'b1});
      else if (state_ff == S_RULE_RD) ram_ra = AW'(WEIGHT_BASE) + AW'(rk_ff);
   end

   fpd_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   // qmul: floor((a*b)/65536), saturated
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return sat32(66'(p >>> 16));
   endfunction

   logic [32:0] abs_n, abs_d;
   logic [63:0] trial;
   logic signed [65:0] qs;
   logic [63:0] dv_rem_sh;
   assign dv_rem_sh = {dv_rem_ff[62:0], dv_num_ff[63]};
   assign trial = dv_rem_sh - dv_den_ff;

   logic signed [31:0] dv_result;
   always_comb begin
      qs = dv_neg_ff ? -$signed({2'b0, dv_q_ff}) : $signed({2'b0, dv_q_ff});
      if (dv_zero_ff) dv_result = dv_nzero_ff ? 32'sd0 : (dv_npos_ff ? SAT_MAX : SAT_MIN);
      else dv_result = sat32(qs);
   end

   logic signed [31:0] mfin;
   assign mfin = sat32(66'(Q_ONE) - 66'(dv_result));

   logic signed [31:0] half_w;
   assign half_w = $signed(ram_rd) / 32'sd2; // power of two, trunc toward zero
   logic signed [32:0] diff;
   logic signed [31:0] xsel;
   assign xsel = (mk_ff < 3'd4) ? x1_ff : x2_ff;
   assign diff = 33'(xsel) - 33'(centre_ff);

   // divider operands per state
   always_comb begin
      dv_go = 1'b0;
      dv_n  = '0;
      dv_d  = '0;
      unique case (state_ff)
         S_ERR: begin
            dv_go = 1'b1;
            dv_n  = e_ff;
            dv_d  = {2'b0, egain_ff};
         end
         S_X1: begin
            dv_go = (dv_cnt_ff == 0);
            dv_n  = de_ff;
            dv_d  = {2'b0, cgain_ff};
         end
         S_MDIST: begin
            dv_go = 1'b1;
            dv_n  = sat32(66'(diff[32] ? -diff : diff));
            dv_d  = 33'(half_w);
         end
         S_AVG: begin
            dv_go = (sat32(66'(den_ff)) != 0);
            dv_n  = sat32(66'(num_ff));
            dv_d  = 33'(sat32(66'(den_ff)));
         end
         default: ;
      endcase
   end

   assign abs_n = dv_n[31] ? 33'(-33'(dv_n)) : 33'(dv_n);
   assign abs_d = dv_d[32] ? 33'(-dv_d) : 33'(dv_d);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         egain_ff  <= 31'd65536;
         cgain_ff  <= 31'd65536;
         ogain_ff  <= Q_ONE;
         prev_ff   <= '0;
         ovalid_ff <= 1'b0;
         dv_cnt_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_ERROR_GAIN:  egain_ff <= csr_wdata[30:0];
               REG_CHANGE_GAIN: cgain_ff <= csr_wdata[30:0];
               REG_OUTPUT_GAIN: ogain_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) ovalid_ff <= 1'b0;
         if (dv_go) begin
            dv_rem_ff   <= '0;
            dv_num_ff   <= {15'd0, abs_n, 16'd0};
            dv_den_ff   <= {31'd0, abs_d};
            dv_q_ff     <= '0;
            dv_cnt_ff   <= 7'd64;
            dv_neg_ff   <= dv_n[31] ^ dv_d[32];
            dv_zero_ff  <= (dv_d == 0);
            dv_npos_ff  <= !dv_n[31] && dv_n != 0;
            dv_nzero_ff <= (dv_n == 0);
         end else if (dv_cnt_ff != 0) begin
            dv_num_ff <= {dv_num_ff[62:0], 1'b0};
            if (trial[63] == 1'b0 && dv_rem_sh >= dv_den_ff) begin
               dv_rem_ff <= trial;
               dv_q_ff   <= {dv_q_ff[62:0], 1'b1};
            end else begin
               dv_rem_ff <= dv_rem_sh;
               dv_q_ff   <= {dv_q_ff[62:0], 1'b0};
            end
            dv_cnt_ff <= dv_cnt_ff - 7'd1;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(COEF_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (acc && op == OP_SAMPLE) begin
               e_ff     <= sat32(66'(measured) - 66'(reference));
               state_ff <= S_ERR;
            end
            S_ERR: begin
               de_ff    <= sat32(66'(e_ff) - 66'(prev_ff));
               prev_ff  <= e_ff;
               state_ff <= S_X1;
            end
            S_X1: if (dv_cnt_ff == 0) begin
               x1_ff    <= dv_result;
               state_ff <= S_X2;
            end
            S_X2: if (dv_cnt_ff == 0) begin
               x2_ff    <= dv_result;
               mk_ff    <= '0;
               state_ff <= S_MRD;
            end
            S_MRD:   state_ff <= S_MWAIT;
            S_MWAIT: begin
               centre_ff <= ram_rd;
               state_ff  <= S_MDIST;
            end
            S_MDIST: state_ff <= S_MDIV;
            S_MDIV: if (dv_cnt_ff == 0) state_ff <= S_MFIN;
            S_MFIN: begin
               if (mk_ff < 3'd4) me_ff[mk_ff[1:0]] <= mfin;
               else mc_ff[2'(mk_ff - 3'd4)] <= mfin;
               if (mk_ff == 3'd6) begin
                  rk_ff    <= '0;
                  den_ff   <= '0;
                  num_ff   <= '0;
                  state_ff <= S_RULE_RD;
               end else begin
                  mk_ff    <= mk_ff + 3'd1;
                  state_ff <= S_MRD;
               end
            end
            S_RULE_RD:   state_ff <= S_RULE_WAIT;
            S_RULE_WAIT: begin
               w_ff     <= ram_rd;
               state_ff <= S_RULE_S;
            end
            S_RULE_S: begin
               s_ff     <= qmul(me_ff[rk_ff[1:0]], mc_ff[rk_ff[3:2]]);
               state_ff <= S_RULE_NUM;
            end
            S_RULE_NUM: begin
               den_ff   <= den_ff + 41'(s_ff);
               num_ff   <= num_ff + 41'(qmul(s_ff, w_ff));
               state_ff <= S_RULE_ACC;
            end
            S_RULE_ACC: begin
               if (rk_ff == 4'(RULE_COUNT - 1)) state_ff <= S_AVG;
               else begin
                  rk_ff    <= rk_ff + 4'd1;
                  state_ff <= S_RULE_RD;
               end
            end
            S_AVG: begin
               if (sat32(66'(den_ff)) == 0) begin
                  out_ff   <= '0;
                  zw_ff    <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  zw_ff    <= 1'b0;
                  state_ff <= S_AVGDIV;
               end
            end
            S_AVGDIV: if (dv_cnt_ff == 0) state_ff <= S_OUTMUL;
            S_OUTMUL: begin
               out_ff   <= qmul(ogain_ff, dv_result);
               state_ff <= S_OUT;
            end
            S_OUT: if (!ovalid_ff) begin
               ovalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // error sets read through the err_slot mapping, weights indexed by rule
   assert property (@(posedge clock) disable iff (reset)
      acc |=> !req_tready || state_ff == S_IDLE)
      else $error("input taken mid-sample");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && zw_ff |-> out_ff == 0)
      else $error("zero weight with nonzero drive");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready)
      else $error("ready during clear");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(out_ff))
      else $error("result dropped");

endmodule

// ===== hdl/fpd_ram.sv =====
module fpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== tb/tb_fuzzy_pd_controller.sv =====
`timescale 1ns / 100ps

module tb_fuzzy_pd_controller;
   import fpd_pkg::*;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               zw;
   } drive_type;

   typedef struct {
      logic               op;
      logic signed [31:0] meas;
      logic signed [31:0] refv;
      logic [4:0]         idx;
      logic signed [31:0] val;
      bit                 typed;
      drive_type          res;
   } row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   fuzzy_pd_controller uut (.*);

   // predictor state
   logic [30:0]        p_err_gain, p_chg_gain;
   logic signed [31:0] p_out_gain;
   logic signed [31:0] p_coef [COEF_WORDS];
   logic signed [31:0] p_prev_err;

   drive_type drive_q[$];
   int        errors = 0;
   bit        hold_req = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic signed [31:0] clip(input longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] q_div(input longint n, input longint d);
      if (d == 0) begin
         if (n > 0) return 32'sh7FFFFFFF;
         if (n < 0) return 32'sh80000000;
         return 0;
      end
      return clip((n * 65536) / d);
   endfunction

   function automatic logic signed [31:0] q_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return clip(p >>> 16);
   endfunction

   function automatic logic signed [31:0] member(input logic signed [31:0] x,
                                                input int slot);
      longint c, w, d;
      c = p_coef[2 * slot];
      w = p_coef[2 * slot + 1];
      d = longint'(x) - c;
      if (d < 0) d = -d;
      return clip(65536 - longint'(q_div(clip(d), w / 2)));
   endfunction

   // returns 1 when the beat produces a result
   function automatic bit fuzzy_drive(input logic op, input logic signed [31:0] meas,
                                      input logic signed [31:0] refv, input logic [4:0] idx,
                                      input logic signed [31:0] val, output drive_type res);
      logic signed [31:0] e, de, x1, x2, s, den32, num32;
      logic signed [31:0] me [4];
      logic signed [31:0] mc [3];
      longint den, num;
      res = '0;
      if (op == OP_LOAD) begin
         if (idx < COEF_WORDS) p_coef[idx] = val;
         return 0;
      end
      e = clip(longint'(meas) - longint'(refv));
      de = clip(longint'(e) - longint'(p_prev_err));
      p_prev_err = e;
      x1 = q_div(e, longint'(p_err_gain));
      x2 = q_div(de, longint'(p_chg_gain));
      for (int k = 0; k < 4; k++) me[k] = member(x1, k);
      for (int k = 0; k < 3; k++) mc[k] = member(x2, 4 + k);
      den = 0;
      num = 0;
      for (int k = 0; k < RULE_COUNT; k++) begin
         s = q_mul(me[err_slot(k[1:0])], mc[k / 4]);
         den += s;
         num += q_mul(s, p_coef[WEIGHT_BASE + k]);
      end
      den32 = clip(den);
      num32 = clip(num);
      if (den32 == 0) begin
         res.zw = 1;
      end else begin
         res.drive = q_mul(p_out_gain, q_div(num32, den32));
      end
      return 1;
   endfunction

   task automatic put_beat(input row_type r, input int gap);
      drive_type pred;
      bit        has;
      req_tvalid <= 1;
      req_tdata <= {2'b0, r.val, r.idx, r.refv, r.meas, r.op};
      do @(posedge clock); while (!req_tready);
      has = fuzzy_drive(r.op, r.meas, r.refv, r.idx, r.val, pred);
      if (has) drive_q.push_back(r.typed ? r.res : pred);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_write(input logic [31:0] eg, input logic [31:0] cg,
                                  input logic [31:0] og);
      while (drive_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1;
      csr_index <= REG_ERROR_GAIN;
      csr_wdata <= eg;
      @(posedge clock);
      csr_index <= REG_CHANGE_GAIN;
      csr_wdata <= cg;
      @(posedge clock);
      csr_index <= REG_OUTPUT_GAIN;
      csr_wdata <= og;
      @(posedge clock);
      csr_we <= 0;
      p_err_gain = eg[30:0];
      p_chg_gain = cg[30:0];
      p_out_gain = og;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      endcase
   endfunction

   row_type dir_rows[$];

   function automatic row_type mk(input logic op, input logic signed [31:0] meas,
                                  input logic signed [31:0] refv, input logic [4:0] idx,
                                  input logic signed [31:0] val);
      row_type r;
      r.op = op; r.meas = meas; r.refv = refv; r.idx = idx; r.val = val;
      r.typed = 0; r.res = '0;
      return r;
   endfunction

   function automatic row_type mk_exp(input row_type r, input logic signed [31:0] d,
                                      input logic zw);
      r.typed = 1;
      r.res.drive = d;
      r.res.zw = zw;
      return r;
   endfunction

   // stimulus
   initial begin
      row_type r;
      int burst, n_items;
      logic [31:0] eg_set [6];
      logic [31:0] cg_set [6];
      logic [31:0] og_set [6];
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      p_err_gain = 31'd65536;
      p_chg_gain = 31'd65536;
      p_out_gain = 32'sd65536;
      p_prev_err = 0;
      foreach (p_coef[i]) p_coef[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // zero table: all weights zero; the first sample at zero error has every membership 1.0
      dir_rows.push_back(mk_exp(mk(OP_SAMPLE, 0, 0, 5'd31, 32'sh7FFFFFFF), 0, 0));
      dir_rows.push_back(mk(OP_SAMPLE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0));
      dir_rows.push_back(mk(OP_SAMPLE, 32'sh80000000, 32'sh7FFFFFFF, 0, 0));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd1, 32'sh20000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd3, 32'sh20000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd5, 32'sh20000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd7, 32'sh20000));
      // every error set at zero, error of 1.0 sits on the foot of each
      dir_rows.push_back(mk_exp(mk(OP_SAMPLE, 32'sh10000, 0, 0, 0), 0, 1));
      dir_rows.push_back(mk(OP_LOAD, 32'sh7FFFFFFF, 32'sh80000000, 5'd26, 32'sh12345));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd31, 32'sh80000000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd0, 32'shFFFE0000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd4, 32'sh10000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd9, 32'sh30000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd11, 32'sh30001));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd13, 32'sh1));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd14, 32'sh7FFFFFFF));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd25, 32'sh80000000));
      dir_rows.push_back(mk(OP_LOAD, 0, 0, 5'd19, 32'shFFFF8000));
      dir_rows.push_back(mk(OP_SAMPLE, 32'sh8000, 0, 0, 0));
      dir_rows.push_back(mk(OP_SAMPLE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
      dir_rows.push_back(mk(OP_SAMPLE, 32'shFFFF0000, 32'sh00010000, 0, 0));
      dir_rows.push_back(mk(OP_SAMPLE, 32'sh80000000, 0, 0, 0));

      foreach (dir_rows[i]) put_beat(dir_rows[i], $urandom_range(0, 2));
      req_tvalid <= 0;

      eg_set = '{32'd1, 32'h7FFFFFFF, 32'h00008000, 32'hFFFFFFFF, 32'h00030000, 32'd65536};
      cg_set = '{32'h7FFFFFFF, 32'd1, 32'h00020000, 32'h00004000, 32'h80010000, 32'd65536};
      og_set = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 32'h00000000, 32'h00028000,
                 32'd65536};

      for (int ph = 0; ph < 6; ph++) begin
         drain_and_write(eg_set[ph], cg_set[ph], og_set[ph]);
         if (ph == 2) hold_req = 1;
         n_items = 0;
         while (n_items < 125) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n_items < 125; b++) begin
               if ($urandom_range(0, 4) == 0) begin
                  r = mk(OP_LOAD, $urandom(), $urandom(), 5'($urandom_range(0, 25)),
                         rand_word());
                  if ($urandom_range(0, 7) == 0) r.idx = 5'($urandom_range(26, 31));
                  // keep widths mostly sensible so memberships land in range
                  if (r.idx < 14 && r.idx[0] && $urandom_range(0, 3) != 0)
                     r.val = $urandom_range(32'h4000, 32'h80000);
               end else begin
                  r = mk(OP_SAMPLE, rand_word(), rand_word(), 5'($urandom()), $urandom());
               end
               n_items++;
               put_beat(r, (b == burst - 1) ? $urandom_range(1, 40) : 0);
            end
         end
         req_tvalid <= 0;
      end

      while (drive_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && drive_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // receiver
   initial begin
      int mode, hold_cnt;
      drive_type want;
      rsp_tready = 0;
      mode = 0;
      hold_cnt = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat: drive %h zw %b",
                                          rsp_tdata, rsp_tuser);
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata !== want.drive || rsp_tuser !== want.zw) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: drive exp %h got %h, zw exp %b got %b",
                              want.drive, rsp_tdata, want.zw, rsp_tuser);
               end
            end
         end
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = 3000;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 0;
         end else begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   initial begin
      #40000000;
      $display("tb: failure");
      $finish;
   end

endmodule
